// ===== hdl/brmu_pkg.sv =====
// Shared types and constants of the block range minimum update engine.
package brmu_pkg;

  localparam int LEN_W       = 11;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 10;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  // Field offsets within in_tdata, lowest bit of each field.
  localparam int POS_LSB = 0;
  localparam int VAL_LSB = POS_LSB + POS_W;
  localparam int LO_LSB  = VAL_LSB + VAL_W;
  localparam int HI_LSB  = LO_LSB + POS_W;

  localparam logic [VAL_W-1:0] ALL_ONES  = '1;
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  typedef enum logic [1:0] {
    SCAN_UPD  = 2'd0,
    SCAN_HEAD = 2'd1,
    SCAN_BLKS = 2'd2,
    SCAN_TAIL = 2'd3
  } scan_mode_t;

  typedef enum logic {
    DIV_SRC_A = 1'b0,
    DIV_SRC_B = 1'b1
  } div_src_t;

  typedef struct packed {
    logic       clear_step;
    logic       capture;
    logic       wr_elem;
    logic       div_start;
    div_src_t   div_src;
    logic       latch_a;
    logic       latch_b;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       wr_blk;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic upd_ok;
    logic quick;
    logic div_busy;
    logic scan_busy;
    logic same_blk;
    logic blk_gap;
    logic out_busy;
  } status_t;

endpackage

// ===== hdl/brmu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/brmu_div.sv =====
// Division by a constant through a rounded-up reciprocal multiply, two register stages.
module brmu_div #(
  parameter int W       = 10,
  parameter int DIVISOR = 32,
  localparam int OFF_W  = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [W-1:0]     dividend,
  output logic             busy,
  output logic [W-1:0]     quotient,
  output logic [OFF_W-1:0] remainder
);

  // With a shift of W + OFF_W bits the rounded-up reciprocal gives the exact
  // quotient for every W-bit dividend.
  localparam int     SH    = W + OFF_W;
  localparam int     PW    = SH + W;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);

  logic             busy_r;
  logic [W-1:0]     x_r;
  logic [PW-1:0]    prod_r;
  logic [W-1:0]     quo_r;
  logic [OFF_W-1:0] rem_r;
  logic [W-1:0]     quo_c;
  logic [W-1:0]     back_c;
  logic [W-1:0]     rem_c;

  always_comb begin
    quo_c  = prod_r[SH +: W];
    back_c = quo_c * W'(DIVISOR);
    rem_c  = x_r - back_c;
  end

  // The first stage multiplies, the second takes the quotient and remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= dividend;
      prod_r <= PW'(dividend) * PW'(RECIP);
    end
    if (busy_r) begin
      quo_r <= quo_c;
      rem_r <= rem_c[OFF_W-1:0];
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/brmu_datapath.sv =====
// Datapath: stores, divider, scan address counter, running minimum and output register.
module brmu_datapath #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int BLOCK_SIZE   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [brmu_pkg::LEN_W-1:0]          cfg_wr_data,
  input  logic                                in_tuser,
  input  logic [brmu_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [brmu_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tuser,
  input  brmu_pkg::cmd_t                      cmd,
  output brmu_pkg::status_t                   status
);

  import brmu_pkg::*;

  localparam int IDX_W      = $clog2(MAX_ELEMENTS);
  localparam int NUM_BLOCKS = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int OFF_W      = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam int CW         = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;

  // Configuration and captured transaction.
  logic [LEN_W-1:0] len_r;
  logic             act_r, upd_ok_r, quick_r, empty_r;
  logic [IDX_W-1:0] a_r, hi_r;
  logic [VAL_W-1:0] val_r;

  // Divider results.
  logic [IDX_W-1:0] qa_r, qb_r;
  logic [OFF_W-1:0] ra_r, rb_r;

  // Scan engine.
  logic [IDX_W-1:0] addr_r, end_r;
  logic             run_r, pend_r, blk_r;
  logic [VAL_W-1:0] acc_r;

  // Output register.
  logic             ovalid_r;
  logic [VAL_W-1:0] omin_r;
  logic             oempty_r;

  logic [CW-1:0]    eff_len, len_m1, pos_w, lo_w, hi_w, lo_c, hi_c;
  logic [CW-1:0]    first_u, top_u, last_u;
  logic [IDX_W-1:0] scan_first, scan_last, div_in, div_q;
  logic [OFF_W-1:0] div_r;
  logic             div_busy;
  logic [VAL_W-1:0] elem_rd, blk_rd, rd_sel;
  logic             elem_we, blk_we;
  logic [IDX_W-1:0] elem_wa;
  logic [VAL_W-1:0] elem_wd, blk_wd;
  logic [BLK_W-1:0] blk_wa;

  always_comb begin
    eff_len = (CW'(len_r) > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : CW'(len_r);
    len_m1  = eff_len - 1'b1;
    pos_w   = CW'(in_tdata[POS_LSB +: POS_W]);
    lo_w    = CW'(in_tdata[LO_LSB +: POS_W]);
    hi_w    = CW'(in_tdata[HI_LSB +: POS_W]);
    lo_c    = (lo_w > len_m1) ? len_m1 : lo_w;
    hi_c    = (hi_w > len_m1) ? len_m1 : hi_w;

    // Block bounds around a_r: first element and last element of its block.
    first_u = CW'(a_r) - CW'(ra_r);
    top_u   = first_u + CW'(BLOCK_SIZE - 1);
    last_u  = (top_u > len_m1) ? len_m1 : top_u;

    unique case (cmd.scan_mode)
      SCAN_UPD: begin
        scan_first = IDX_W'(first_u);
        scan_last  = IDX_W'(last_u);
      end
      SCAN_HEAD: begin
        scan_first = a_r;
        scan_last  = (qa_r == qb_r) ? hi_r : IDX_W'(top_u);
      end
      SCAN_BLKS: begin
        scan_first = qa_r + 1'b1;
        scan_last  = qb_r - 1'b1;
      end
      SCAN_TAIL: begin
        scan_first = hi_r - IDX_W'(rb_r);
        scan_last  = hi_r;
      end
      default: begin
        scan_first = a_r;
        scan_last  = a_r;
      end
    endcase

    div_in = (cmd.div_src == DIV_SRC_B) ? hi_r : a_r;
    rd_sel = blk_r ? blk_rd : elem_rd;

    elem_we = cmd.clear_step | cmd.wr_elem;
    elem_wa = cmd.clear_step ? addr_r : a_r;
    elem_wd = cmd.clear_step ? ALL_ONES : val_r;
    blk_we  = (cmd.clear_step & (CW'(addr_r) < CW'(NUM_BLOCKS))) | cmd.wr_blk;
    blk_wa  = cmd.clear_step ? addr_r[BLK_W-1:0] : qa_r[BLK_W-1:0];
    blk_wd  = cmd.clear_step ? ALL_ONES : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_wr_en) begin
      len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r    <= in_tuser;
      val_r    <= in_tdata[VAL_LSB +: VAL_W];
      upd_ok_r <= (pos_w < eff_len);
      empty_r  <= (lo_w > hi_w);
      quick_r  <= (lo_w > hi_w) | (eff_len == '0);
      a_r      <= in_tuser ? IDX_W'(lo_c) : IDX_W'(pos_w);
      hi_r     <= IDX_W'(hi_c);
    end
    if (cmd.latch_a) begin
      qa_r <= div_q;
      ra_r <= div_r;
    end
    if (cmd.latch_b) begin
      qb_r <= div_q;
      rb_r <= div_r;
    end
  end

  // The counter walks the clearing pass after reset and every scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      run_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= run_r;
      if (cmd.clear_step) begin
        addr_r <= addr_r + 1'b1;
      end else if (cmd.scan_start) begin
        addr_r <= scan_first;
        run_r  <= 1'b1;
      end else if (run_r) begin
        if (addr_r == end_r) begin
          run_r <= 1'b0;
        end else begin
          addr_r <= addr_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      end_r <= scan_last;
      blk_r <= (cmd.scan_mode == SCAN_BLKS);
    end
    if (cmd.capture) begin
      acc_r <= ALL_ONES;
    end else if (pend_r) begin
      acc_r <= (rd_sel < acc_r) ? rd_sel : acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      omin_r   <= acc_r;
      oempty_r <= empty_r;
    end
  end

  brmu_div #(
    .W       (IDX_W),
    .DIVISOR (BLOCK_SIZE)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_in),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  brmu_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_elem_ram (
    .clk     (clk),
    .wr_en   (elem_we),
    .wr_addr (elem_wa),
    .wr_data (elem_wd),
    .rd_addr (addr_r),
    .rd_data (elem_rd)
  );

  brmu_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NUM_BLOCKS)
  ) u_blk_ram (
    .clk     (clk),
    .wr_en   (blk_we),
    .wr_addr (blk_wa),
    .wr_data (blk_wd),
    .rd_addr (addr_r[BLK_W-1:0]),
    .rd_data (blk_rd)
  );

  always_comb begin
    status.clear_last = (addr_r == IDX_W'(MAX_ELEMENTS - 1));
    status.is_query   = act_r;
    status.upd_ok     = upd_ok_r;
    status.quick      = quick_r;
    status.div_busy   = div_busy;
    status.scan_busy  = run_r | pend_r;
    status.same_blk   = (qa_r == qb_r);
    status.blk_gap    = ((CW'(qa_r) + 1'b1) < CW'(qb_r));
    status.out_busy   = ovalid_r & ~out_tready;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = omin_r;
  assign out_tuser  = oempty_r;

endmodule

// ===== hdl/brmu_ctrl.sv =====
// Controller state machine sequencing clearing, updates and queries.
module brmu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  brmu_pkg::status_t status,
  output brmu_pkg::cmd_t    cmd
);

  import brmu_pkg::*;

  typedef enum logic [9:0] {
    ST_CLEAR    = 10'b00_0000_0001,
    ST_IDLE     = 10'b00_0000_0010,
    ST_CHECK    = 10'b00_0000_0100,
    ST_DIV_A    = 10'b00_0000_1000,
    ST_DIV_B    = 10'b00_0001_0000,
    ST_PLAN     = 10'b00_0010_0000,
    ST_SCAN_E1  = 10'b00_0100_0000,
    ST_SCAN_BLK = 10'b00_1000_0000,
    ST_SCAN_E2  = 10'b01_0000_0000,
    ST_FINISH   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status.is_query) begin
          if (status.upd_ok) begin
            cmd.wr_elem   = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_SRC_A;
            state_nxt     = ST_DIV_A;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (status.quick) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DIV_SRC_A;
          state_nxt     = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        if (!status.div_busy) begin
          cmd.latch_a = 1'b1;
          if (status.is_query) begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_SRC_B;
            state_nxt     = ST_DIV_B;
          end else begin
            state_nxt = ST_PLAN;
          end
        end
      end
      ST_DIV_B: begin
        if (!status.div_busy) begin
          cmd.latch_b = 1'b1;
          state_nxt   = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cmd.scan_start = 1'b1;
        cmd.scan_mode  = status.is_query ? SCAN_HEAD : SCAN_UPD;
        state_nxt      = ST_SCAN_E1;
      end
      ST_SCAN_E1: begin
        if (!status.scan_busy) begin
          if (!status.is_query) begin
            cmd.wr_blk = 1'b1;
            state_nxt  = ST_IDLE;
          end else if (status.same_blk) begin
            state_nxt = ST_FINISH;
          end else if (status.blk_gap) begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_BLKS;
            state_nxt      = ST_SCAN_BLK;
          end else begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_TAIL;
            state_nxt      = ST_SCAN_E2;
          end
        end
      end
      ST_SCAN_BLK: begin
        if (!status.scan_busy) begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = SCAN_TAIL;
          state_nxt      = ST_SCAN_E2;
        end
      end
      ST_SCAN_E2: begin
        if (!status.scan_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

endmodule

// ===== hdl/block_range_min_update.sv =====
// Top level of the block range minimum update engine.
//
//  Channel  Direction  Handshake             Contents
//  in_      slave      in_tvalid/in_tready   one update or query transaction
//  out_     master     out_tvalid/out_tready one query result transaction
//  cfg_     write      cfg_wr_en             array_length register
//
// After reset a clearing pass writes all ones into every element and every block
// minimum, one entry a cycle; no transaction is taken then.
// Items are handled one at a time. The block rescan sets the time of an update;
// the block index comes from a reciprocal multiply. The scans set the time of a
// query; the single read port of each store sets the scan length. An empty or
// zero-length query skips the divider and the scans. A result waits in the output
// register while the next transaction is taken; only a second finished result
// waits for out_tready.
module block_range_min_update #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int BLOCK_SIZE   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration: array_length.
  input  logic                             cfg_wr_en,
  input  logic [brmu_pkg::LEN_W-1:0]       cfg_wr_data,
  // Input transaction.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata from bit 0: position[9:0], new_value[41:10], range_low[51:42],
  // range_high[61:52], zero fill[63:62].
  input  logic [brmu_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: action (0 update, 1 query).
  input  logic                             in_tuser,
  // Result transaction.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata from bit 0: minimum[31:0].
  output logic [brmu_pkg::OUT_TDATA_W-1:0] out_tdata,
  // tuser: empty_range.
  output logic                             out_tuser
);

  import brmu_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller sequences each transaction; the datapath holds both stores.
  brmu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  brmu_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .BLOCK_SIZE   (BLOCK_SIZE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// ===== test/tb_block_range_min_update.sv =====
// Self-checking testbench for the block range minimum update engine.
`timescale 1ns / 100ps

module tb_block_range_min_update;
  import brmu_pkg::*;

  // Sizes of the instance under test (its parameter defaults).
  localparam int ELEMENTS  = 1024;
  localparam int BLK       = 32;
  localparam int NUM_BLKS  = ELEMENTS / BLK;

  // Idle time after the last result before a register write or the end of the run.
  // An update produces no result, yet its block rescan can still be running.
  localparam int SETTLE_CYCLES = 200;
  // Length of the receiver's long hold-off used to fill the block up.
  localparam int LONG_HOLD     = 1500;
  // Watchdog, far above the slowest correct run.
  localparam int LIMIT_CYCLES  = 1000000;

  typedef enum logic {
    ACT_UPDATE = 1'b0,
    ACT_QUERY  = 1'b1
  } action_t;

  typedef struct packed {
    logic [VAL_W-1:0] minimum;
    logic             empty_range;
  } range_min_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // Mirror of the block's state, kept by the scoreboard process.
  logic [VAL_W-1:0] elem_mem [ELEMENTS];
  logic [VAL_W-1:0] blk_min [NUM_BLKS];
  logic [LEN_W-1:0] len_reg;

  // Query results still to come out of the block, oldest first.
  range_min_t expected_minima [$];

  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  // When set, neither side idles: a stretch of back-to-back traffic.
  bit burst_mode = 1'b0;
  // Asks the result sink for one long hold-off; it clears the flag when done.
  bit long_hold_req = 1'b0;

  block_range_min_update uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction. The array length is capped at the store size; elements and
  // block minima follow every accepted update.
  // ---------------------------------------------------------------------------

  function automatic int eff_length();
    return (int'(len_reg) < ELEMENTS) ? int'(len_reg) : ELEMENTS;
  endfunction

  function automatic logic [VAL_W-1:0] scan_elements(int first, int last,
                                                     logic [VAL_W-1:0] acc);
    for (int i = first; i <= last && i < ELEMENTS; i++)
      if (elem_mem[i] < acc) acc = elem_mem[i];
    return acc;
  endfunction

  function automatic void apply_update(int pos, logic [VAL_W-1:0] val);
    int len;
    int blk;
    int first;
    int last;
    len = eff_length();
    // Writes at or beyond the array length leave everything untouched.
    if (pos >= len) return;
    elem_mem[pos] = val;
    blk   = pos / BLK;
    first = blk * BLK;
    last  = first + BLK - 1;
    if (last > len - 1) last = len - 1;
    blk_min[blk] = scan_elements(first, last, ALL_ONES);
  endfunction

  function automatic range_min_t predict_range_min(int lo, int hi);
    range_min_t res;
    int len;
    int lb;
    int hb;
    len = eff_length();
    res.minimum     = ALL_ONES;
    res.empty_range = 1'b0;
    // Emptiness is judged on the raw ends, before any clamping.
    if (lo > hi) begin
      res.empty_range = 1'b1;
      return res;
    end
    if (len > 0) begin
      if (lo > len - 1) lo = len - 1;
      if (hi > len - 1) hi = len - 1;
      lb = lo / BLK;
      hb = hi / BLK;
      if (lb == hb) begin
        res.minimum = scan_elements(lo, hi, res.minimum);
      end else begin
        res.minimum = scan_elements(lo, (lb + 1) * BLK - 1, res.minimum);
        // Whole blocks in between come from the stored minima, stale or not.
        for (int b = lb + 1; b < hb && b < NUM_BLKS; b++)
          if (blk_min[b] < res.minimum) res.minimum = blk_min[b];
        res.minimum = scan_elements(hb * BLK, hi, res.minimum);
      end
    end
    return res;
  endfunction

  // Scoreboard: checks each result transaction first, then takes in the
  // transaction accepted at the same edge, so the order within a step is fixed.
  always @(posedge clk) begin : scoreboard
    range_min_t want;
    if (!rst_n) begin
      len_reg = LEN_RESET;
      for (int i = 0; i < ELEMENTS; i++) elem_mem[i] = ALL_ONES;
      for (int b = 0; b < NUM_BLKS; b++) blk_min[b] = ALL_ONES;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_minima.size() == 0) begin
          $error("unexpected result transaction: minimum %h, empty_range %b",
                 out_tdata, out_tuser);
          failures++;
        end else begin
          want = expected_minima.pop_front();
          if (out_tdata[VAL_W-1:0] !== want.minimum) begin
            $error("minimum: expected %h, got %h", want.minimum, out_tdata[VAL_W-1:0]);
            failures++;
          end
          if (out_tuser !== want.empty_range) begin
            $error("empty_range: expected %b, got %b", want.empty_range, out_tuser);
            failures++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (action_t'(in_tuser) == ACT_UPDATE)
          apply_update(int'(in_tdata[POS_LSB +: POS_W]), in_tdata[VAL_LSB +: VAL_W]);
        else
          expected_minima.push_back(predict_range_min(int'(in_tdata[LO_LSB +: POS_W]),
                                                      int'(in_tdata[HI_LSB +: POS_W])));
      end
      if (cfg_wr_en) len_reg = cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Idle gaps: mostly none or short, now and then a long one.
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Result sink. A long hold-off, when asked for, is counted here so the
  // sender keeps offering transactions until the block stalls its input.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        out_tready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task starts and ends on a rising edge.
  // ---------------------------------------------------------------------------

  // Offers one transaction and returns at the edge where it is accepted.
  // Valid stays high into the next transaction when no gap is wanted.
  task automatic send_item(action_t act, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                           logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= act;
    in_tdata  <= {2'b00, hi, lo, val, pos};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Fields that the action does not use carry random content.
  task automatic send_update(int pos, logic [VAL_W-1:0] val);
    send_item(ACT_UPDATE, POS_W'(pos), val, POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic send_query(int lo, int hi);
    send_item(ACT_QUERY, POS_W'($urandom), VAL_W'($urandom), POS_W'(lo), POS_W'(hi));
  endtask

  // Drops valid, waits for every outstanding result and lets a trailing
  // update finish its rescan.
  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    while (expected_minima.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_array_length(int len);
    wait_until_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= LEN_W'(len);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 85) return $urandom_range(0, 255);
    if (r < 90) return '0;
    if (r < 95) return ALL_ONES;
    return ALL_ONES - $urandom_range(0, 15);
  endfunction

  // One random transaction, shaped by the current array length so that most
  // updates land and most queries cover written elements.
  task automatic random_item(int update_pct);
    int len;
    int top;
    int r;
    int a;
    int b;
    int lim;
    len = eff_length();
    top = (len > 0) ? len - 1 : 0;
    if ($urandom_range(0, 99) < update_pct) begin
      r = $urandom_range(0, 99);
      if (r < 60)      a = $urandom_range(0, top);
      else if (r < 85) a = $urandom_range(0, (top < 127) ? top : 127);
      else             a = $urandom_range(0, ELEMENTS - 1);
      send_update(a, pick_value());
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // Empty range.
        a = $urandom_range(1, ELEMENTS - 1);
        b = $urandom_range(0, a - 1);
      end else if (r < 25) begin
        // Both ends inside one block.
        a   = $urandom_range(0, top);
        lim = a - (a % BLK) + BLK - 1;
        b   = $urandom_range(a, (lim < top) ? lim : top);
      end else if (r < 70) begin
        a = $urandom_range(0, top);
        b = $urandom_range(0, top);
        if (a > b) begin
          lim = a;
          a   = b;
          b   = lim;
        end
      end else if (r < 80) begin
        a = 0;
        b = ELEMENTS - 1;
      end else begin
        a = $urandom_range(0, ELEMENTS - 1);
        b = $urandom_range(0, ELEMENTS - 1);
      end
      send_query(a, b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // After the clearing pass every element reads as all ones.
  task automatic test_reset_contents();
    send_query(0, ELEMENTS - 1);
  endtask

  // Extremes of index and value, partial and whole blocks, empty ranges.
  task automatic test_directed_ranges();
    send_update(0, '0);
    send_update(ELEMENTS - 1, ALL_ONES - 1);
    send_update(45, 32'd3);
    send_update(31, 32'd5);
    send_update(32, ALL_ONES);
    send_update(700, 32'h8000_0000);
    send_query(0, 0);
    send_query(ELEMENTS - 1, ELEMENTS - 1);
    send_query(1, ELEMENTS - 1);
    send_query(31, 32);
    send_query(46, ELEMENTS - 1);
    send_query(5, 3);
    send_query(ELEMENTS - 1, 0);
  endtask

  // Short, zero and oversized array lengths; a block minimum refreshed under a
  // short length stays stale once the length grows again.
  task automatic test_length_limits();
    set_array_length(40);
    send_update(40, 32'd1);
    send_update(33, 32'd100);
    send_update(39, 32'd9);
    send_query(0, ELEMENTS - 1);
    send_query(50, 60);
    send_query(60, 50);
    set_array_length(0);
    send_update(0, '0);
    send_query(0, 0);
    send_query(3, 2);
    set_array_length(2047);
    send_query(2, 100);
    set_array_length(1);
    send_update(0, 32'h1234_5678);
    send_query(0, ELEMENTS - 1);
  endtask

  // The receiver holds off for a long time while queries keep coming, so the
  // output register and the finished result behind it fill and input stalls.
  task automatic test_backpressure();
    set_array_length(1024);
    burst_mode    = 1'b1;
    long_hold_req = 1'b1;
    for (int k = 0; k < 12; k++) begin
      if (k % 3 == 2) send_query(9, 8);
      else            send_query($urandom_range(0, 200), $urandom_range(300, ELEMENTS - 1));
    end
    burst_mode = 1'b0;
    in_tvalid <= 1'b0;
    while (long_hold_req) @(posedge clk);
    wait_until_idle();
  endtask

  // Random traffic in phases, one array length per phase. One phase runs with
  // no idling on either side.
  task automatic test_random_traffic();
    int lengths [10];
    int len;
    lengths = '{1024, 1024, 97, 1, 0, 2047, 1024, 512, 33, 1024};
    for (int ph = 0; ph < 10; ph++) begin
      len = (ph == 7) ? $urandom_range(2, 1023) : lengths[ph];
      set_array_length(len);
      burst_mode = (ph == 6);
      // The first phase leans on updates to populate the store.
      repeat (50) random_item((ph == 0) ? 75 : 45);
      burst_mode = 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_contents();
    test_directed_ranges();
    test_length_limits();
    test_backpressure();
    test_random_traffic();
    wait_until_idle();
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
